// ===== rtl/meu_pkg.sv =====
// ----------------------------------------------------------------------------
// meu_pkg: shared types and constants of the modular exponentiation unit
// fixed field widths, operation codes, engine command and sequencer states
// ----------------------------------------------------------------------------
package meu_pkg;

    // fixed field widths
    localparam int OP_WIDTH   = 2;
    localparam int DATA_WIDTH = 64;
    localparam int RES_WIDTH  = 62;
    localparam int CFG_WIDTH  = 62;

    // serial operand window: signed 64-bit operand minus two needs 65 bits
    localparam int SER_WIDTH  = DATA_WIDTH + 1;
    localparam int CNT_WIDTH  = $clog2(SER_WIDTH + 1);

    // modulus after reset, 2^61 - 1
    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 62'h1FFF_FFFF_FFFF_FFFF;

    // operation codes, the unused code runs as a plain power
    localparam logic [OP_WIDTH-1:0] OP_POWER   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_INVERSE = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_SQRT    = 2'd2;

    // command to the bit-serial modular engine
    typedef struct packed {
        logic                 start;
        logic                 mul;
        logic [CNT_WIDTH-1:0] nbits;
    } meu_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_RED_EXP,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } meu_state_t;

endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: right-to-left square and multiply mod m
// base^exponent mod modulus with a bit-serial modular engine
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one word: operation, base, operand
//   output channel (out_valid/out_ready) gives one word: result
//   the modulus is written through cfg_wr_en/cfg_wr_data; the user must do so only while
//   the unit is idle; the unit itself does not enforce this
// sequence
//   base reduction and exponent reduction, then per exponent bit a square and, where the
//   bit is set, a multiply; the top bit skips its square and goes on to the output register
// throughput
//   one word at a time; a new word is taken as soon as the previous one has
//   reached the output register, even while that result waits to be taken
// reset
//   rst_n clears the control state and loads the modulus with 2^61 - 1
// stall
//   a held result stalls only the final hand-off of the next word
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
    parameter int MODULUS_WIDTH = 62
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [meu_pkg::CFG_WIDTH-1:0]        cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [meu_pkg::OP_WIDTH-1:0]         operation,
    input  logic [meu_pkg::DATA_WIDTH-1:0]       base,
    input  logic [meu_pkg::DATA_WIDTH-1:0]       operand,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [meu_pkg::RES_WIDTH-1:0]        result
);

    localparam int W  = MODULUS_WIDTH;
    localparam int SW = meu_pkg::SER_WIDTH;
    localparam int DW = meu_pkg::DATA_WIDTH;

    meu_pkg::meu_state_t state_reg, state_next;

    logic [W-1:0]                   modulus_reg;
    logic                           bneg_reg, bneg_next;
    logic                           eneg_reg, eneg_next;
    logic [SW-1:0]                  eser_reg, eser_next;
    logic [W-1:0]                   a_reg, a_next;
    logic [W-1:0]                   ret_reg, ret_next;
    logic [W-1:0]                   exp_reg, exp_next;
    logic [meu_pkg::RES_WIDTH-1:0]  result_reg, result_next;
    logic                           out_valid_reg, out_valid_next;

    // engine hookup
    meu_pkg::meu_cmd_t  cmd;
    logic [W-1:0]       eng_mcand;
    logic [SW-1:0]      eng_serial;
    logic               eng_done;
    logic [W-1:0]       eng_acc;

    // operand preparation
    logic               accept;
    logic [DW-1:0]      bmag;
    logic [SW-1:0]      ov;
    logic [SW-1:0]      emag;
    logic [W:0]         m_inc;
    logic               mod_small;
    logic               fix_neg;
    logic [W-1:0]       fix_val;
    logic [SW-1:0]      a_serial;

    assign accept    = in_valid && (state_reg == meu_pkg::ST_IDLE);
    assign mod_small = (modulus_reg[W-1:1] == '0);

    // sign and magnitude of base and exponent
    always_comb
    begin
        bmag  = base[DW-1] ? (DW'(0) - base) : base;
        ov    = {operand[DW-1], operand}
              - ((operation == meu_pkg::OP_INVERSE) ? SW'(2) : SW'(0));
        m_inc = {1'b0, modulus_reg} + (W+1)'(1);
        if (operation == meu_pkg::OP_SQRT)
        begin
            eneg_next = 1'b0;
            emag      = SW'(m_inc[W:2]);
        end
        else
        begin
            eneg_next = ov[SW-1];
            emag      = ov[SW-1] ? (SW'(0) - ov) : ov;
        end
    end

    // negative values map to m - r unless the residue is zero
    assign fix_neg  = (state_reg == meu_pkg::ST_RED_BASE) ? bneg_reg : eneg_reg;
    assign fix_val  = (fix_neg && (eng_acc != '0)) ? (modulus_reg - eng_acc) : eng_acc;
    assign a_serial = {a_reg, {(SW-W){1'b0}}};

    always_comb
    begin
        state_next     = state_reg;
        bneg_next      = bneg_reg;
        eser_next      = eser_reg;
        a_next         = a_reg;
        ret_next       = ret_reg;
        exp_next       = exp_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        cmd.start      = 1'b0;
        cmd.mul        = 1'b0;
        cmd.nbits      = meu_pkg::CNT_WIDTH'(W);
        eng_mcand      = a_reg;
        eng_serial     = a_serial;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            meu_pkg::ST_IDLE:
            begin
                eng_serial = {bmag, 1'b0};
                cmd.nbits  = meu_pkg::CNT_WIDTH'(DW);
                if (in_valid)
                begin
                    bneg_next = base[DW-1];
                    eser_next = emag;
                    if (mod_small)
                    begin
                        ret_next   = '0;
                        state_next = meu_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = meu_pkg::ST_RED_BASE;
                    end
                end
            end
            meu_pkg::ST_RED_BASE:
            begin
                eng_serial = eser_reg;
                cmd.nbits  = meu_pkg::CNT_WIDTH'(SW);
                if (eng_done)
                begin
                    a_next     = fix_val;
                    cmd.start  = 1'b1;
                    state_next = meu_pkg::ST_RED_EXP;
                end
            end
            meu_pkg::ST_RED_EXP:
            begin
                if (eng_done)
                begin
                    exp_next   = fix_val;
                    ret_next   = W'(1);
                    // zero exponent gives one
                    state_next = (fix_val == '0) ? meu_pkg::ST_DONE : meu_pkg::ST_STEP;
                end
            end
            meu_pkg::ST_STEP:
            begin
                // multiply on a set bit, then square unless it is the top bit; square on a clear bit
                cmd.start = 1'b1;
                cmd.mul   = 1'b1;
                if (exp_reg[0])
                begin
                    eng_mcand  = ret_reg;
                    state_next = meu_pkg::ST_MUL;
                end
                else
                    state_next = meu_pkg::ST_SQR;
            end
            meu_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (eng_done)
                begin
                    ret_next = eng_acc;
                    if (exp_reg[W-1:1] == '0)
                        state_next = meu_pkg::ST_DONE;
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = meu_pkg::ST_SQR;
                    end
                end
            end
            meu_pkg::ST_SQR:
            begin
                cmd.mul = 1'b1;
                if (eng_done)
                begin
                    a_next     = eng_acc;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = meu_pkg::ST_STEP;
                end
            end
            meu_pkg::ST_DONE:
            begin
                // hand off once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    result_next    = meu_pkg::RES_WIDTH'(ret_reg);
                    out_valid_next = 1'b1;
                    state_next     = meu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = meu_pkg::ST_IDLE;
            end
        endcase
    end

    meu_mod_engine #(
        .MODULUS_WIDTH(MODULUS_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .modulus (modulus_reg),
        .mcand   (eng_mcand),
        .serial  (eng_serial),
        .done    (eng_done),
        .acc     (eng_acc)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= meu_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            modulus_reg   <= meu_pkg::MODULUS_RESET[W-1:0];
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                modulus_reg <= cfg_wr_data[W-1:0];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bneg_reg   <= bneg_next;
        eneg_reg   <= accept ? eneg_next : eneg_reg;
        eser_reg   <= eser_next;
        a_reg      <= a_next;
        ret_reg    <= ret_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign in_ready  = (state_reg == meu_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/meu_mod_engine.sv =====
// ----------------------------------------------------------------------------
// meu_mod_engine: bit-serial modular accumulate engine
// one bit of the serial operand per cycle, msb first: acc = 2*acc + addend mod m
// the addend is the serial bit itself (reduction) or the multiplicand (product)
// ----------------------------------------------------------------------------
module meu_mod_engine #(
    parameter int MODULUS_WIDTH = 62
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  meu_pkg::meu_cmd_t                  cmd,
    input  logic [MODULUS_WIDTH-1:0]           modulus,
    input  logic [MODULUS_WIDTH-1:0]           mcand,
    input  logic [meu_pkg::SER_WIDTH-1:0]      serial,
    output logic                               done,
    output logic [MODULUS_WIDTH-1:0]           acc
);

    localparam int W = MODULUS_WIDTH;
    localparam int SW = meu_pkg::SER_WIDTH;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           mul_reg, mul_next;
    logic [meu_pkg::CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]                  sr_reg, sr_next;
    logic [W-1:0]                   mcand_reg, mcand_next;
    logic [W-1:0]                   acc_reg, acc_next;

    logic [W-1:0]   addend;
    logic [W+1:0]   dbl;
    logic [W+2:0]   sub1;
    logic [W+2:0]   sub2;
    logic [W-1:0]   step;

    // doubled accumulator plus addend stays below 3m
    always_comb
    begin
        if (mul_reg)
            addend = sr_reg[SW-1] ? mcand_reg : '0;
        else
            addend = {{(W-1){1'b0}}, sr_reg[SW-1]};
        dbl  = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
        sub1 = {1'b0, dbl} - {3'b000, modulus};
        sub2 = {1'b0, dbl} - {2'b00, modulus, 1'b0};
        if (!sub2[W+2])
            step = sub2[W-1:0];
        else if (!sub1[W+2])
            step = sub1[W-1:0];
        else
            step = dbl[W-1:0];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        mul_next   = mul_reg;
        cnt_next   = cnt_reg;
        sr_next    = sr_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            mul_next   = cmd.mul;
            cnt_next   = cmd.nbits;
            sr_next    = serial;
            mcand_next = mcand;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            sr_next  = {sr_reg[SW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == meu_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg   <= mul_next;
        cnt_reg   <= cnt_next;
        sr_reg    <= sr_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// ===== tb/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_unit: self-checking bench for the modexp unit
// drives power, inverse and square-root words through valid/ready, predicts
// every result with a wide-arithmetic square-and-multiply and checks in order
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_unit;

    // the fourth operation code is not named in the package, it runs as a power
    localparam logic [meu_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;

    // watchdog limit for the whole run; about 100 words with stalls fit well below it
    localparam int LIMIT_CYCLES = 4_000_000;
    // quiet time after the last result, about one worst-case word
    localparam int TAIL_CYCLES  = 8300;

    localparam logic [meu_pkg::DATA_WIDTH-1:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [meu_pkg::DATA_WIDTH-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [meu_pkg::CFG_WIDTH-1:0]  MOD_MAX = {meu_pkg::CFG_WIDTH{1'b1}};
    localparam logic [meu_pkg::CFG_WIDTH-1:0]  MOD_MIN = 62'd2;

    // one accepted word and the residue it must produce
    typedef struct {
        logic [meu_pkg::OP_WIDTH-1:0]   op;
        logic [meu_pkg::DATA_WIDTH-1:0] base_word;
        logic [meu_pkg::DATA_WIDTH-1:0] exp_word;
        logic [meu_pkg::RES_WIDTH-1:0]  value;
    } power_expect_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [meu_pkg::CFG_WIDTH-1:0]  cfg_wr_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [meu_pkg::OP_WIDTH-1:0]   operation;
    logic [meu_pkg::DATA_WIDTH-1:0] base;
    logic [meu_pkg::DATA_WIDTH-1:0] operand;
    logic                           out_valid;
    logic                           out_ready;
    logic [meu_pkg::RES_WIDTH-1:0]  result;

    power_expect_t                  expected_powers[$];
    logic [meu_pkg::CFG_WIDTH-1:0]  modulus_now;     // bench copy of the modulus register
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             mismatches;
    int                             cycles;

    modular_exponentiation_unit #(
        .MODULUS_WIDTH(62)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .base       (base),
        .operand    (operand),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // nonnegative residue of a signed value wide enough for operand minus two
    function automatic logic [meu_pkg::RES_WIDTH-1:0] signed_residue(
        input logic signed [65:0] v,
        input logic [meu_pkg::CFG_WIDTH-1:0] m
    );
        logic [65:0] mag;
        logic [65:0] r;
        if (v[65])
            mag = -v;
        else
            mag = v;
        r = mag % {4'd0, m};
        // a negative value folds back from the top of the range
        if (v[65] && r != 0)
            r = {4'd0, m} - r;
        return r[meu_pkg::RES_WIDTH-1:0];
    endfunction

    function automatic logic [meu_pkg::RES_WIDTH-1:0] mul_residue(
        input logic [meu_pkg::RES_WIDTH-1:0] a,
        input logic [meu_pkg::RES_WIDTH-1:0] b,
        input logic [meu_pkg::CFG_WIDTH-1:0] m
    );
        logic [123:0] p;
        p = {62'd0, a} * {62'd0, b};
        p = p % {62'd0, m};
        return p[meu_pkg::RES_WIDTH-1:0];
    endfunction

    function automatic logic [meu_pkg::RES_WIDTH-1:0] predict_power(
        input logic [meu_pkg::OP_WIDTH-1:0]   op,
        input logic [meu_pkg::DATA_WIDTH-1:0] b,
        input logic [meu_pkg::DATA_WIDTH-1:0] x,
        input logic [meu_pkg::CFG_WIDTH-1:0]  m
    );
        logic [meu_pkg::RES_WIDTH-1:0] acc;
        logic [meu_pkg::RES_WIDTH-1:0] sq;
        logic [meu_pkg::RES_WIDTH-1:0] e;
        logic [62:0]                   half;
        // a modulus below two collapses everything to zero
        if (m < 2)
            return '0;
        sq = signed_residue($signed({{2{b[63]}}, b}), m);
        case (op)
            meu_pkg::OP_SQRT:
            begin
                half = ({1'b0, m} + 63'd1) >> 2;
                e = signed_residue($signed({3'b000, half}), m);
            end
            meu_pkg::OP_INVERSE:
                e = signed_residue($signed({{2{x[63]}}, x}) - 66'sd2, m);
            default:
                e = signed_residue($signed({{2{x[63]}}, x}), m);
        endcase
        // zero exponent gives one, zero base included
        acc = 62'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_residue(acc, sq, m);
            sq = mul_residue(sq, sq, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------------
    // driving side
    // ------------------------------------------------------------------------

    // one input word; the expectation is queued at the accepting edge
    task automatic send_word(
        input logic [meu_pkg::OP_WIDTH-1:0]   op,
        input logic [meu_pkg::DATA_WIDTH-1:0] b,
        input logic [meu_pkg::DATA_WIDTH-1:0] x
    );
        power_expect_t item;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        base      <= b;
        operand   <= x;
        do
            @(posedge clk);
        while (!in_ready);
        item.op        = op;
        item.base_word = b;
        item.exp_word  = x;
        item.value     = predict_power(op, b, x, modulus_now);
        expected_powers.push_back(item);
    endtask

    // drop valid and hold off until every queued result has been taken
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
    endtask

    // only called with the unit idle
    task automatic set_modulus(input logic [meu_pkg::CFG_WIDTH-1:0] m);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        modulus_now = m;
    endtask

    // operand or base values: full range, small signed, near the modulus, corners, random negatives
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = rand64();
            2:    v = 64'($urandom_range(0, 40)) - 64'd20;
            3:    v = 64'(modulus_now) * 64'($urandom_range(0, 3))
                      + 64'($urandom_range(0, 2)) - 64'd1;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = S64_MIN;
                    1:       v = S64_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = rand64() | S64_MIN;
        endcase
        return v;
    endfunction

    function automatic logic [meu_pkg::CFG_WIDTH-1:0] pick_modulus();
        logic [meu_pkg::CFG_WIDTH-1:0] m;
        case ($urandom_range(0, 4))
            0: m = meu_pkg::MODULUS_RESET;
            1: m = 62'd1000003;
            2: m = 62'd3;
            3: m = {1'b1, 61'(rand64())} | 62'd1;
            default:
            begin
                m = 62'(rand64() >> $urandom_range(2, 60));
                if (m < 2)
                    m = MOD_MIN;
            end
        endcase
        return m;
    endfunction

    function automatic logic [meu_pkg::OP_WIDTH-1:0] pick_op();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return meu_pkg::OP_POWER;
            4, 5, 6:    return meu_pkg::OP_INVERSE;
            7, 8:       return meu_pkg::OP_SQRT;
            default:    return OP_UNUSED;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // receiving side and checking
    // ------------------------------------------------------------------------

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // every taken result word is matched against the oldest expectation
    always @(posedge clk)
    begin
        power_expect_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("result word with nothing expected: result %0d", result);
                mismatches++;
            end
            else
            begin
                head = expected_powers.pop_front();
                if (result !== head.value)
                begin
                    $error("result mismatch: expected %0d, actual %0d (op %0d base %h operand %h)",
                           head.value, result, head.op, head.base_word, head.exp_word);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // power at the reset modulus 2^61-1 with extreme bases and exponents
    task automatic test_power_extremes();
        send_word(meu_pkg::OP_POWER, 64'd3, 64'd5);
        send_word(meu_pkg::OP_POWER, S64_MIN, S64_MAX);
        send_word(meu_pkg::OP_POWER, S64_MAX, S64_MIN);
        send_word(meu_pkg::OP_POWER, '1, 64'd3);
        send_word(meu_pkg::OP_POWER, '0, '0);              // zero to the zero is one
        send_word(meu_pkg::OP_POWER, 64'd7, 64'(meu_pkg::MODULUS_RESET)); // exponent folds to zero
        send_word(meu_pkg::OP_POWER, '0, 64'd5);
        send_word(meu_pkg::OP_POWER, 64'd10, '1);          // negative exponent
    endtask

    // inverse: exponent is operand minus two, including negative results
    task automatic test_inverse();
        send_word(meu_pkg::OP_INVERSE, 64'd12345, 64'(meu_pkg::MODULUS_RESET));
        send_word(meu_pkg::OP_INVERSE, 64'd5, 64'd2);      // exponent exactly zero
        send_word(meu_pkg::OP_INVERSE, 64'd5, 64'd0);
        send_word(meu_pkg::OP_INVERSE, 64'd5, 64'd1);
        send_word(meu_pkg::OP_INVERSE, -64'd3, S64_MIN);   // operand minus two needs 65 bits
        send_word(meu_pkg::OP_INVERSE, S64_MAX, S64_MAX);
    endtask

    // square root ignores the operand; the unused code acts as power
    task automatic test_sqrt_and_unused_op();
        send_word(meu_pkg::OP_SQRT, 64'd4, rand64());
        send_word(meu_pkg::OP_SQRT, '1, '0);
        send_word(meu_pkg::OP_SQRT, S64_MIN, S64_MAX);
        send_word(OP_UNUSED, 64'd2, 64'd10);
        send_word(OP_UNUSED, S64_MIN, S64_MIN);
    endtask

    // smallest and largest modulus, sender paused until the unit has drained
    task automatic test_modulus_extremes();
        wait_drained();
        set_modulus(MOD_MIN);
        send_word(meu_pkg::OP_POWER, '1, 64'd1);
        send_word(meu_pkg::OP_SQRT, 64'd1, '0);            // (2+1)>>2 is a zero exponent
        send_word(meu_pkg::OP_INVERSE, 64'd3, 64'd3);
        wait_drained();
        set_modulus(MOD_MAX);
        send_word(meu_pkg::OP_POWER, S64_MAX, S64_MAX);
        send_word(meu_pkg::OP_INVERSE, S64_MIN, S64_MIN);
        send_word(meu_pkg::OP_POWER, 64'd2, 64'd61);
    endtask

    // random words under one idling style, modulus changed every few words
    task automatic test_random_traffic(input int words, input int send_pct,
                                       input int recv_pct);
        logic [meu_pkg::OP_WIDTH-1:0] op;
        logic [63:0]                  b;
        logic [63:0]                  x;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < words; k++)
        begin
            if (k % 11 == 0)
            begin
                wait_drained();
                set_modulus(pick_modulus());
            end
            op = pick_op();
            b  = pick_value();
            x  = pick_value();
            // prime-style inverse exponents now and then
            if (op == meu_pkg::OP_INVERSE && $urandom_range(0, 2) == 0)
                x = 64'(modulus_now);
            send_word(op, b, x);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        operation     = meu_pkg::OP_POWER;
        base          = '0;
        operand       = '0;
        out_ready     = 1'b0;
        modulus_now   = meu_pkg::MODULUS_RESET;
        send_idle_pct = 34;
        recv_idle_pct = 73;
        mismatches    = 0;
        cycles        = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words run with the first idling style
        test_power_extremes();
        test_inverse();
        test_sqrt_and_unused_op();
        test_modulus_extremes();

        // sender sparse and receiver stalling, then swapped, then full rate
        test_random_traffic(25, 34, 73);
        test_random_traffic(25, 73, 34);
        test_random_traffic(25, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_powers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
